// ----- rtl/bst_pkg.sv -----
// Shared constants, codes and control structs for the bounded set table.
// Used by every module in the rtl folder; depends on nothing else.
package bst_pkg;

    // Table size and element width
    localparam int CAPACITY   = 128;
    localparam int DATA_WIDTH = 32;

    // Derived widths
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int FIELD_W = 8;
    localparam int CMP_W   = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
    localparam int NGROUPS = (CAPACITY + 7) / 8;
    localparam int GRP_W   = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
    localparam int SCAN_W  = ((GRP_W + 4) > CNT_W) ? (GRP_W + 4) : CNT_W;

    // Stream widths
    localparam int IN_W  = 48;
    localparam int OUT_W = 24;

    // Command codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_ERASE  = 2'd1;
    localparam logic [1:0] ACT_APPEND = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DUP    = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic                  cmp;
        logic                  ins;
        logic                  del;
        logic [IDX_W-1:0]      pos;
        logic [DATA_WIDTH-1:0] val;
        logic [CNT_W-1:0]      count;
    } cell_ctrl_t;

    // Report of the first-match scan
    typedef struct packed {
        logic             done;
        logic             found;
        logic [IDX_W-1:0] index;
    } scan_res_t;

endpackage

// ----- rtl/bst_cell.sv -----
// One table entry: holds its value, shifts from its neighbors on insert or erase,
// and registers whether it matches the broadcast value. Depends on bst_pkg.
module bst_cell (
    input  logic                          clk,
    input  logic [bst_pkg::IDX_W-1:0]      idx,
    input  bst_pkg::cell_ctrl_t            ctrl,
    input  logic [bst_pkg::DATA_WIDTH-1:0] left_val,
    input  logic [bst_pkg::DATA_WIDTH-1:0] right_val,
    output logic [bst_pkg::DATA_WIDTH-1:0] entry,
    output logic                          match
);
    import bst_pkg::*;

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    logic                  match_reg;
    logic                  match_next;

    // Pick the new entry: take the value, shift up from the left, or down from the right
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (idx == ctrl.pos)
                entry_next = ctrl.val;
            else if (idx > ctrl.pos)
                entry_next = left_val;
        end
        else if (ctrl.del)
        begin
            if (idx >= ctrl.pos)
                entry_next = right_val;
        end
    end

    // Match only while this entry lies below the count
    assign match_next = (entry_reg == ctrl.val) && (CNT_W'(idx) < ctrl.count);

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (ctrl.cmp)
            match_reg <= match_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

// ----- rtl/bst_scan.sv -----
// First-match finder: walks the cell match flags eight at a time, lowest first,
// stopping at a hit or past the count. Depends on bst_pkg.
module bst_scan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bst_pkg::NGROUPS*8-1:0] match_vec,
    input  logic [bst_pkg::CNT_W-1:0]     count,
    output bst_pkg::scan_res_t          res
);
    import bst_pkg::*;

    logic             busy_reg;
    logic             busy_next;
    logic [GRP_W-1:0] grp_reg;
    logic [GRP_W-1:0] grp_next;
    logic [7:0]       hits;
    logic [2:0]       enc;
    logic [SCAN_W-1:0] next_base;
    logic             stop;
    logic             done;

    // Select the current group of flags
    assign hits = match_vec[{grp_reg, 3'b000} +: 8];

    // Lowest set flag in the group
    always_comb
    begin
        enc = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (hits[k])
                enc = 3'(k);
        end
    end

    // Stop after the last group or once the next group starts at or past the count
    assign next_base = SCAN_W'({1'b0, grp_reg} + {{GRP_W{1'b0}}, 1'b1}) << 3;
    assign stop      = (grp_reg == GRP_W'(NGROUPS - 1)) || (next_base >= SCAN_W'(count));
    assign done      = busy_reg && ((|hits) || stop);

    always_comb
    begin
        busy_next = busy_reg;
        grp_next  = grp_reg;
        if (start)
        begin
            busy_next = 1'b1;
            grp_next  = '0;
        end
        else if (done)
            busy_next = 1'b0;
        else if (busy_reg)
            grp_next = grp_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            grp_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            grp_reg  <= grp_next;
        end
    end

    assign res.done  = done;
    assign res.found = |hits;
    assign res.index = IDX_W'({grp_reg, enc});

endmodule

// ----- rtl/bounded_set_table.sv -----
// Top level of the bounded set table: command controller, row of entry cells,
// first-match scan and result register. Depends on bst_pkg, bst_cell, bst_scan.
//
// Usage:
//   Commands enter on the s_axis channel (tvalid/tready/tdata); each yields one
//   result item on the m_axis channel. Commands: insert at position (rejected
//   as duplicate, full or bad position), erase at position, append, clear.
//   Sequence: erase, append, clear and rejected inserts pass from the check state
//   to the done state and then into the result register. An insert that passes
//   the range checks first scans the match flags eight entries per cycle, ending
//   early when a duplicate sits low in the table, then goes to the done state.
//   Throughput: one command at a time; the next command is accepted as soon as
//   the controller is back to idle, even while the last result still waits.
//   For the shift, every cell loads from its neighbor at once.
//   Reset clears the count and the control state; stored values are not cleared
//   and are never visible, since only entries below the count are read.
//   When the receiver stalls, the result holds in its register and a finished
//   command waits in the controller until the register frees up.
module bounded_set_table (
    input  logic                      clk,
    input  logic                      rst_n,
    // s_tdata: action[1:0], position[9:2], value[41:10], zero pad above
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [bst_pkg::IN_W-1:0]  s_tdata,
    // m_tdata: status[1:0], result_position[9:2], entry_count[17:10],
    //          is_empty[18], zero pad above
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [bst_pkg::OUT_W-1:0] m_tdata
);
    import bst_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [1:0]            act_reg;
    logic [FIELD_W-1:0]    pos_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [1:0]            rstat_reg;
    logic [1:0]            rstat_next;
    logic [FIELD_W-1:0]    rpos_reg;
    logic [FIELD_W-1:0]    rpos_next;
    logic                  mvalid_reg;
    logic                  mvalid_next;
    logic [OUT_W-1:0]      mdata_reg;
    logic [OUT_W-1:0]      mdata_next;

    logic                  s_accept;
    logic                  out_free;
    logic                  scan_start;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic                  is_full;
    cell_ctrl_t            ctrl;
    scan_res_t             scan;
    logic [DATA_WIDTH-1:0] entry_row [CAPACITY];
    logic [NGROUPS*8-1:0]  match_vec;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;
    assign pos_ext  = CMP_W'(pos_reg);
    assign cnt_ext  = CMP_W'(count_reg);
    assign is_full  = (count_reg >= CNT_W'(CAPACITY));

    // Latch the command on accept
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            act_reg <= s_tdata[1:0];
            pos_reg <= s_tdata[9:2];
            val_reg <= DATA_WIDTH'(s_tdata[41:10]);
        end
    end

    // Command controller
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rstat_next  = rstat_reg;
        rpos_next   = rpos_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        scan_start  = 1'b0;
        ctrl.cmp    = 1'b0;
        ctrl.ins    = 1'b0;
        ctrl.del    = 1'b0;
        ctrl.pos    = IDX_W'(pos_reg);
        ctrl.val    = val_reg;
        ctrl.count  = count_reg;

        if (mvalid_reg && m_tready)
            mvalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_DONE;
                rstat_next = ST_OK;
                rpos_next  = '0;
                unique case (act_reg)
                    ACT_INSERT:
                    begin
                        if (is_full)
                            rstat_next = ST_FULL;
                        else if (pos_ext > cnt_ext)
                            rstat_next = ST_BADPOS;
                        else
                        begin
                            // Compare every cell, then hunt for the first hit
                            ctrl.cmp   = 1'b1;
                            scan_start = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    ACT_ERASE:
                    begin
                        if (pos_ext >= cnt_ext)
                            rstat_next = ST_BADPOS;
                        else
                        begin
                            ctrl.del   = 1'b1;
                            count_next = count_reg - 1'b1;
                            rpos_next  = pos_reg;
                        end
                    end
                    ACT_APPEND:
                    begin
                        if (is_full)
                            rstat_next = ST_FULL;
                        else
                        begin
                            ctrl.ins   = 1'b1;
                            ctrl.pos   = IDX_W'(count_reg);
                            count_next = count_reg + 1'b1;
                            rpos_next  = FIELD_W'(count_reg);
                        end
                    end
                    ACT_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        count_next = count_reg;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (scan.done)
                begin
                    state_next = S_DONE;
                    if (scan.found)
                    begin
                        rstat_next = ST_DUP;
                        rpos_next  = FIELD_W'(scan.index);
                    end
                    else
                    begin
                        ctrl.ins   = 1'b1;
                        count_next = count_reg + 1'b1;
                        rstat_next = ST_OK;
                        rpos_next  = pos_reg;
                    end
                end
            end
            S_DONE:
            begin
                // Hand the result to the output register once it is free
                if (out_free)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = OUT_W'({(count_reg == '0), FIELD_W'(count_reg),
                                          rpos_reg, rstat_reg});
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge clk)
    begin
        rstat_reg <= rstat_next;
        rpos_reg  <= rpos_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    // Row of entry cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_val;
        logic [DATA_WIDTH-1:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_val = val_reg;
        end
        else
        begin : g_mid_l
            assign left_val = entry_row[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_val = entry_row[i];
        end
        else
        begin : g_mid_r
            assign right_val = entry_row[i+1];
        end

        bst_cell u_cell (
            .clk       (clk),
            .idx       (IDX_W'(i)),
            .ctrl      (ctrl),
            .left_val  (left_val),
            .right_val (right_val),
            .entry     (entry_row[i]),
            .match     (match_vec[i])
        );
    end

    // Pad flags beyond the last cell
    if (NGROUPS * 8 > CAPACITY)
    begin : g_pad
        assign match_vec[NGROUPS*8-1:CAPACITY] = '0;
    end

    bst_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .match_vec (match_vec),
        .count     (count_reg),
        .res       (scan)
    );

endmodule

// ----- rtl/bst_checker.sv -----
// Port-level checks for the bounded set table, attached to the top by bind.
// Depends on bst_pkg and bounded_set_table.
module bst_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic [bst_pkg::IN_W-1:0]  s_tdata,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [bst_pkg::OUT_W-1:0] m_tdata
);
    import bst_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Empty flag tracks the count
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[18] == (m_tdata[17:10] == 8'd0)) || (CAPACITY > 255))
        else $error("empty flag disagrees with count");

    // Rejected as full or bad position reports position zero
    a_reject_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == ST_FULL || m_tdata[1:0] == ST_BADPOS)
        |-> m_tdata[9:2] == 8'd0)
        else $error("rejected command reports nonzero position");

    // No result appears in the cycle right after a command is taken
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result too early");

    // Pad bits stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_W-1:19] == '0)
        else $error("result pad bits set");

endmodule

bind bounded_set_table bst_checker u_bst_checker (.*);

// ----- sim/tb.sv -----
// Self-checking testbench for bounded_set_table: directed and random commands,
// each result checked against a cycle-free model of the table kept here.
// Depends on rtl/bst_pkg.sv and rtl/bounded_set_table.sv.
`timescale 1ns / 100ps

module tb;
    import bst_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 40;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] position;
        logic [7:0] entry_count;
        logic       is_empty;
    } table_result_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    // Model state of the table
    logic [DATA_WIDTH-1:0] set_vals [CAPACITY];
    int                    set_count;

    table_result_t expected_results [$];
    int            errors;
    int            stall_cycles;
    bit            no_gaps;

    bounded_set_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one command to the model table and return the result it yields
    function automatic table_result_t apply_command(input logic [1:0] act,
                                                    input logic [7:0] pos,
                                                    input logic [31:0] val);
        table_result_t         r;
        logic [DATA_WIDTH-1:0] v;
        int                    i;
        int                    hit;
        v          = val;
        hit        = -1;
        r.status   = ST_OK;
        r.position = '0;
        case (act)
            ACT_INSERT:
            begin
                if (set_count >= CAPACITY)
                    r.status = ST_FULL;
                else if (pos > set_count)
                    r.status = ST_BADPOS;
                else
                begin
                    for (i = 0; i < set_count; i++)
                        if (hit < 0 && set_vals[i] == v)
                            hit = i;
                    if (hit >= 0)
                    begin
                        r.status   = ST_DUP;
                        r.position = hit[7:0];
                    end
                    else
                    begin
                        // shift the tail up by one and drop the value in
                        for (i = set_count; i > pos; i--)
                            set_vals[i] = set_vals[i-1];
                        set_vals[pos] = v;
                        set_count++;
                        r.position = pos;
                    end
                end
            end
            ACT_ERASE:
            begin
                if (pos >= set_count)
                    r.status = ST_BADPOS;
                else
                begin
                    for (i = pos; i + 1 < set_count; i++)
                        set_vals[i] = set_vals[i+1];
                    set_count--;
                    r.position = pos;
                end
            end
            ACT_APPEND:
            begin
                if (set_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    set_vals[set_count] = v;
                    r.position = set_count[7:0];
                    set_count++;
                end
            end
            default:
                set_count = 0;
        endcase
        r.entry_count = set_count[7:0];
        r.is_empty    = (set_count == 0);
        return r;
    endfunction

    // Send one command item, idling first at random; log its expected result
    task automatic send_item(input logic [1:0] act, input logic [7:0] pos,
                             input logic [31:0] val);
        while (!no_gaps && $urandom_range(99) < 14)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, val, pos, act};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(apply_command(act, pos, val));
    endtask

    // Hold the sender until every outstanding result has come back
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Mix stored values, a narrow pool and full-range values to provoke duplicates
    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 20 && set_count > 0)
            return set_vals[$urandom_range(set_count - 1)];
        else if (roll < 40)
            return $urandom_range(255);
        return $urandom();
    endfunction

    // Build one random command, biased toward filling or draining the table
    task automatic random_command(input bit grow);
        int         roll;
        logic [1:0] act;
        logic [7:0] pos;
        logic [31:0] val;
        roll = $urandom_range(99);
        val  = pick_value();
        pos  = 8'($urandom_range(255));
        if ($urandom_range(299) == 0)
            act = ACT_CLEAR;
        else if (roll < 10)
            act = 2'($urandom_range(2));
        else if (roll < (grow ? 55 : 25))
        begin
            act = ACT_INSERT;
            pos = 8'($urandom_range(set_count));
        end
        else if (roll < (grow ? 80 : 38))
            act = ACT_APPEND;
        else
        begin
            act = ACT_ERASE;
            pos = (set_count == 0) ? 8'd0 : 8'($urandom_range(set_count - 1));
        end
        send_item(act, pos, val);
    endtask

    // Edge values, every command and the duplicate and bad-position rejections on a small table
    task automatic test_directed_cases();
        send_item(ACT_ERASE,  8'd0,   32'h0);
        send_item(ACT_INSERT, 8'd1,   32'h5);
        send_item(ACT_INSERT, 8'd255, 32'h0);
        send_item(ACT_INSERT, 8'd0,   32'h0000_0000);
        send_item(ACT_INSERT, 8'd1,   32'hFFFF_FFFF);
        send_item(ACT_INSERT, 8'd1,   32'hA5A5_5A5A);
        send_item(ACT_INSERT, 8'd0,   32'hFFFF_FFFF);
        send_item(ACT_INSERT, 8'd3,   32'h0000_0000);
        send_item(ACT_APPEND, 8'd0,   32'hFFFF_FFFF);
        send_item(ACT_INSERT, 8'd4,   32'h8000_0001);
        send_item(ACT_INSERT, 8'd0,   32'hFFFF_FFFF);
        send_item(ACT_ERASE,  8'd255, 32'h0);
        send_item(ACT_ERASE,  8'd5,   32'h0);
        send_item(ACT_ERASE,  8'd0,   32'h0);
        send_item(ACT_ERASE,  8'd3,   32'h0);
        send_item(ACT_CLEAR,  8'd170, 32'h5555_AAAA);
        send_item(ACT_ERASE,  8'd0,   32'h0);
        send_item(ACT_CLEAR,  8'd0,   32'h0);
        send_item(ACT_APPEND, 8'd85,  32'h7FFF_FFFE);
        send_item(ACT_INSERT, 8'd0,   32'h7FFF_FFFE);
        send_item(ACT_INSERT, 8'd128, 32'h1);
        hold_until_drained();
    endtask

    // Fill to capacity, then hit every rejection that fullness takes precedence over
    task automatic test_capacity_limits();
        send_item(ACT_CLEAR, 8'd0, 32'h0);
        while (set_count < CAPACITY)
            send_item(ACT_APPEND, 8'($urandom_range(255)), $urandom());
        send_item(ACT_INSERT, 8'd0,   32'h1234_5678);
        send_item(ACT_INSERT, 8'd255, 32'h1234_5678);
        send_item(ACT_INSERT, 8'd5,   set_vals[3]);
        send_item(ACT_APPEND, 8'd0,   32'hDEAD_0001);
        send_item(ACT_ERASE,  8'd128, 32'h0);
        send_item(ACT_ERASE,  8'd127, 32'h0);
        send_item(ACT_INSERT, 8'd127, set_vals[0]);
        send_item(ACT_INSERT, 8'd127, 32'hFFFF_FFFF);
        hold_until_drained();
        send_item(ACT_ERASE,  8'd0,   32'h0);
        send_item(ACT_INSERT, 8'd0,   $urandom());
        send_item(ACT_CLEAR,  8'd255, 32'hFFFF_FFFF);
        hold_until_drained();
    endtask

    // Swing the table between empty and full with random content
    task automatic test_random_traffic(input int n_items);
        bit grow;
        int k;
        grow = 1'b1;
        for (k = 0; k < n_items; k++)
        begin
            no_gaps = (k < 300);
            if (k % 500 == 499)
                hold_until_drained();
            if (grow && set_count >= CAPACITY && $urandom_range(9) == 0)
                grow = 1'b0;
            else if (!grow && set_count == 0)
                grow = 1'b1;
            random_command(grow);
        end
        no_gaps = 1'b0;
    endtask

    // Check each accepted result against the oldest expectation; stall at random
    always @(posedge clk)
    begin : result_check
        table_result_t got;
        table_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[1:0], m_tdata[9:2], m_tdata[17:10], m_tdata[18]};
            if (expected_results.size() == 0)
            begin
                if (errors < REPORT_MAX)
                    $display("%0t: unexpected result %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    if (errors < REPORT_MAX)
                        $display("%0t: mismatch status %0d/%0d position %0d/%0d count %0d/%0d empty %0d/%0d (exp/act)",
                                 $time, want.status, got.status, want.position, got.position,
                                 want.entry_count, got.entry_count, want.is_empty, got.is_empty);
                    errors++;
                end
            end
        end
        m_tready <= no_gaps || ($urandom_range(99) >= 14);
    end

    // End the run when nothing moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
            $display("** bounded_set_table: FAILED **");
            $finish;
        end
    end

    initial
    begin
        errors    = 0;
        set_count = 0;
        no_gaps   = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_capacity_limits();
        test_random_traffic(2000);
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("** bounded_set_table: PASSED **");
        else
            $display("** bounded_set_table: FAILED **");
        $finish;
    end

endmodule
